// File: rtl/alle_pkg.sv
// ---------------------------------------------------------------------------
// alle_pkg: shared types and microcode for the linked list engine
// Operation and status codes, the control word layout and the read-only
// program that drives the engine's datapath one step per cycle while not stalled.
// ---------------------------------------------------------------------------
package alle_pkg;

   localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
   localparam logic [2:0] FUNC_INS_END   = 3'd1;
   localparam logic [2:0] FUNC_INS_AFTER = 3'd2;
   localparam logic [2:0] FUNC_DEL_FRONT = 3'd3;
   localparam logic [2:0] FUNC_DEL_END   = 3'd4;
   localparam logic [2:0] FUNC_DEL_AFTER = 3'd5;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_EMPTY  = 3'd2;
   localparam logic [2:0] ST_NOKEY  = 3'd3;
   localparam logic [2:0] ST_NOSUCC = 3'd4;

   // program step addresses
   typedef enum logic [4:0] {
      S_I0A   = 5'd0,
      S_I0B   = 5'd1,
      S_I1A   = 5'd2,
      S_I1B   = 5'd3,
      S_I1C   = 5'd4,
      S_I1D   = 5'd5,
      S_I1E   = 5'd6,
      S_K2A   = 5'd7,
      S_K2B   = 5'd8,
      S_K2C   = 5'd9,
      S_I2A   = 5'd10,
      S_I2B   = 5'd11,
      S_I2C   = 5'd12,
      S_NOKEY = 5'd13,
      S_D3A   = 5'd14,
      S_D3B   = 5'd15,
      S_D4A   = 5'd16,
      S_D4B   = 5'd17,
      S_D4C   = 5'd18,
      S_D4D   = 5'd19,
      S_D4E   = 5'd20,
      S_D4F   = 5'd21,
      S_K5A   = 5'd22,
      S_K5B   = 5'd23,
      S_K5C   = 5'd24,
      S_D5A   = 5'd25,
      S_D5B   = 5'd26,
      S_D5C   = 5'd27,
      S_NOSUC = 5'd28,
      S_ERR   = 5'd29
   } step_type;

   // node store read: address source
   typedef enum logic [1:0] {RD_NONE, RD_HEAD, RD_FREE, RD_NEXT} rd_type;
   // link write address source
   typedef enum logic [1:0] {WA_NONE, WA_NODE, WA_CUR, WA_PRV} wa_type;
   // link write value source
   typedef enum logic [2:0] {
      WV_HEAD, WV_NULL, WV_PRV, WV_NODE, WV_FREE, WV_RLINK
   } wv_type;
   typedef enum logic [1:0] {HD_KEEP, HD_NODE, HD_RLINK, HD_NULL} hd_type;
   typedef enum logic [1:0] {FR_KEEP, FR_RLINK, FR_CUR} fr_type;
   typedef enum logic [2:0] {
      C_NONE, C_HEAD_NULL, C_RLINK_NULL, C_STOP, C_MATCH
   } cond_type;
   typedef enum logic [2:0] {
      FIN_NONE, FIN_OK, FIN_NOKEY, FIN_NOSUCC, FIN_PRE
   } fin_type;

   typedef struct packed {
      rd_type   rd;    // read issued only when the jump is not taken
      logic     wd;    // write item into the head free node
      wa_type   wa;
      wv_type   wv;
      hd_type   hd;
      fr_type   fr;
      logic     rm;    // capture read data as removed value
      logic     sv;    // save read link into prv
      cond_type cond;
      step_type jmp;
      step_type nxt;
      fin_type  fin;
   } ctl_type;

   function automatic ctl_type ucode(step_type s);
      ctl_type c;
      c.rd   = RD_NONE;
      c.wd   = 1'b0;
      c.wa   = WA_NONE;
      c.wv   = WV_NULL;
      c.hd   = HD_KEEP;
      c.fr   = FR_KEEP;
      c.rm   = 1'b0;
      c.sv   = 1'b0;
      c.cond = C_NONE;
      c.jmp  = S_ERR;
      c.nxt  = S_ERR;
      c.fin  = FIN_NONE;
      case (s)
         // insert front
         S_I0A: begin
            c.rd = RD_FREE; c.wd = 1'b1; c.nxt = S_I0B;
         end
         S_I0B: begin
            c.wa = WA_NODE; c.wv = WV_HEAD; c.hd = HD_NODE; c.fr = FR_RLINK;
            c.fin = FIN_OK;
         end
         // insert end
         S_I1A: begin
            c.rd = RD_FREE; c.wd = 1'b1; c.nxt = S_I1B;
         end
         S_I1B: begin
            c.wa = WA_NODE; c.wv = WV_NULL; c.fr = FR_RLINK; c.rd = RD_HEAD;
            c.cond = C_HEAD_NULL; c.jmp = S_I1E; c.nxt = S_I1C;
         end
         S_I1C: begin
            c.rd = RD_NEXT; c.cond = C_RLINK_NULL; c.jmp = S_I1D; c.nxt = S_I1C;
         end
         S_I1D: begin
            c.wa = WA_CUR; c.wv = WV_NODE; c.fin = FIN_OK;
         end
         S_I1E: begin
            c.hd = HD_NODE; c.fin = FIN_OK;
         end
         // insert after key
         S_K2A: begin
            c.rd = RD_HEAD; c.cond = C_HEAD_NULL; c.jmp = S_NOKEY; c.nxt = S_K2B;
         end
         S_K2B: begin
            c.rd = RD_NEXT; c.cond = C_STOP; c.jmp = S_K2C; c.nxt = S_K2B;
         end
         S_K2C: begin
            c.sv = 1'b1; c.cond = C_MATCH; c.jmp = S_I2A; c.nxt = S_NOKEY;
         end
         S_I2A: begin
            c.rd = RD_FREE; c.wd = 1'b1; c.nxt = S_I2B;
         end
         S_I2B: begin
            c.wa = WA_NODE; c.wv = WV_PRV; c.fr = FR_RLINK; c.nxt = S_I2C;
         end
         S_I2C: begin
            c.wa = WA_CUR; c.wv = WV_NODE; c.fin = FIN_OK;
         end
         S_NOKEY: begin
            c.fin = FIN_NOKEY;
         end
         // delete front
         S_D3A: begin
            c.rd = RD_HEAD; c.nxt = S_D3B;
         end
         S_D3B: begin
            c.rm = 1'b1; c.hd = HD_RLINK; c.wa = WA_CUR; c.wv = WV_FREE;
            c.fr = FR_CUR; c.fin = FIN_OK;
         end
         // delete end
         S_D4A: begin
            c.rd = RD_HEAD; c.nxt = S_D4B;
         end
         S_D4B: begin
            c.rd = RD_NEXT; c.cond = C_RLINK_NULL; c.jmp = S_D4F; c.nxt = S_D4C;
         end
         S_D4C: begin
            c.rd = RD_NEXT; c.cond = C_RLINK_NULL; c.jmp = S_D4D; c.nxt = S_D4C;
         end
         S_D4D: begin
            c.rm = 1'b1; c.wa = WA_PRV; c.wv = WV_NULL; c.nxt = S_D4E;
         end
         S_D4E: begin
            c.wa = WA_CUR; c.wv = WV_FREE; c.fr = FR_CUR; c.fin = FIN_OK;
         end
         S_D4F: begin
            c.rm = 1'b1; c.hd = HD_NULL; c.wa = WA_CUR; c.wv = WV_FREE;
            c.fr = FR_CUR; c.fin = FIN_OK;
         end
         // delete after key
         S_K5A: begin
            c.rd = RD_HEAD; c.nxt = S_K5B;
         end
         S_K5B: begin
            c.rd = RD_NEXT; c.cond = C_STOP; c.jmp = S_K5C; c.nxt = S_K5B;
         end
         S_K5C: begin
            c.cond = C_MATCH; c.jmp = S_D5A; c.nxt = S_NOKEY;
         end
         S_D5A: begin
            c.rd = RD_NEXT; c.cond = C_RLINK_NULL; c.jmp = S_NOSUC; c.nxt = S_D5B;
         end
         S_D5B: begin
            c.rm = 1'b1; c.wa = WA_PRV; c.wv = WV_RLINK; c.nxt = S_D5C;
         end
         S_D5C: begin
            c.wa = WA_CUR; c.wv = WV_FREE; c.fr = FR_CUR; c.fin = FIN_OK;
         end
         S_NOSUC: begin
            c.fin = FIN_NOSUCC;
         end
         S_ERR: begin
            c.fin = FIN_PRE;
         end
         default: begin
            c.fin = FIN_PRE;
         end
      endcase
      return c;
   endfunction

endpackage

// File: rtl/alle_node_store.sv
// ---------------------------------------------------------------------------
// alle_node_store: node data and link memories
// One registered read port shared by both arrays, one write port each.
// ---------------------------------------------------------------------------
module alle_node_store #(
   parameter int NODE_COUNT = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [$clog2(NODE_COUNT)-1:0]        rd_addr,
   input  logic                                 lk_we,
   input  logic [$clog2(NODE_COUNT)-1:0]        lk_addr,
   input  logic [$clog2(NODE_COUNT+1)-1:0]      lk_wdata,
   input  logic                                 dt_we,
   input  logic [$clog2(NODE_COUNT)-1:0]        dt_addr,
   input  logic [DATA_WIDTH-1:0]                dt_wdata,
   output logic [$clog2(NODE_COUNT+1)-1:0]      rd_link,
   output logic [DATA_WIDTH-1:0]                rd_data
);

   localparam int LW = $clog2(NODE_COUNT + 1);

   logic [LW-1:0]         link_mem [NODE_COUNT];
   logic [DATA_WIDTH-1:0] data_mem [NODE_COUNT];
   logic [LW-1:0]         rd_link_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_addr] <= lk_wdata;
      end
      if (dt_we) begin
         data_mem[dt_addr] <= dt_wdata;
      end
      // hold the last read when idle
      if (rd_en) begin
         rd_link_ff <= link_mem[rd_addr];
         rd_data_ff <= data_mem[rd_addr];
      end
   end

   assign rd_link = rd_link_ff;
   assign rd_data = rd_data_ff;

endmodule

// File: rtl/array_linked_list_engine.sv
// ---------------------------------------------------------------------------
// array_linked_list_engine: singly linked list in a fixed node store
// A data list and a free list share NODE_COUNT nodes; a microcoded
// sequencer runs one short program per request.
// ---------------------------------------------------------------------------
// Each request beat carries one operation (insert front, insert end, insert
// after key, delete front, delete end, delete after key) and returns one
// response beat with the removed value and a status. After reset the block
// runs a clearing pass that chains every node onto the free list; req_stall
// stays high meanwhile. The engine then takes one request at a time. Insert
// end, delete end and the keyed operations walk the list: one link is
// followed per cycle through the single registered read port of the node
// store. Full and empty requests run only the error step and answer with
// their status; unused codes run the same step and answer with ST_OK. A
// request is taken while the previous response beat still waits; the
// program only stalls at its final step until the response register
// frees up.
// ---------------------------------------------------------------------------
module array_linked_list_engine #(
   parameter int NODE_COUNT = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_item_value,
   input  logic signed [31:0] req_key_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_removed_value,
   output logic [2:0]         rsp_status
);

   localparam int LW = $clog2(NODE_COUNT + 1);   // link width, null included
   localparam int IW = $clog2(NODE_COUNT);       // node index width
   localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

   // sequencer state
   logic                   init_ff, init_in;
   logic [LW-1:0]          init_cnt_ff, init_cnt_in;
   logic                   busy_ff, busy_in;
   alle_pkg::step_type     upc_ff, upc_in;
   logic [2:0]             pre_status_ff, pre_status_in;

   // datapath registers
   logic [LW-1:0]          head_ff, head_in;
   logic [LW-1:0]          free_ff, free_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [LW-1:0]          prv_ff, prv_in;
   logic [LW-1:0]          node_ff, node_in;
   logic [DATA_WIDTH-1:0]  item_ff, item_in;
   logic [DATA_WIDTH-1:0]  key_ff, key_in;
   logic signed [DATA_WIDTH-1:0] removed_ff, removed_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     rsp_removed_ff, rsp_removed_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   // store interface
   logic                   rd_en;
   logic [LW-1:0]          rd_addr;
   logic                   lk_we;
   logic [LW-1:0]          lk_addr;
   logic [LW-1:0]          lk_wdata;
   logic                   dt_we;
   logic [LW-1:0]          rlink;
   logic [DATA_WIDTH-1:0]  rdata;

   alle_pkg::ctl_type      ctl;
   logic                   go;
   logic                   taken;
   logic                   req_take;
   logic                   match;
   logic signed [63:0]     item_wide;
   logic signed [63:0]     key_wide;
   logic signed [63:0]     removed_wide;

   assign ctl       = alle_pkg::ucode(upc_ff);
   assign req_stall = busy_ff | init_ff;
   assign req_take  = req_valid & ~req_stall;
   assign item_wide = 64'(req_item_value);
   assign key_wide  = 64'(req_key_value);
   assign removed_wide = 64'(removed_ff);
   assign match     = (rdata == key_ff);

   // advance a step unless it is a final step facing a full response register
   assign go = busy_ff &
               ~((ctl.fin != alle_pkg::FIN_NONE) & rsp_valid_ff & rsp_stall);

   always_comb begin
      case (ctl.cond)
         alle_pkg::C_HEAD_NULL:  taken = (head_ff >= NIL);
         alle_pkg::C_RLINK_NULL: taken = (rlink >= NIL);
         alle_pkg::C_STOP:       taken = match | (rlink >= NIL);
         alle_pkg::C_MATCH:      taken = match;
         default:                taken = 1'b0;
      endcase
   end

   // read address; a read is skipped on a taken jump or a null pointer
   always_comb begin
      case (ctl.rd)
         alle_pkg::RD_HEAD: rd_addr = head_ff;
         alle_pkg::RD_FREE: rd_addr = free_ff;
         alle_pkg::RD_NEXT: rd_addr = rlink;
         default:           rd_addr = NIL;
      endcase
      rd_en = go & (ctl.rd != alle_pkg::RD_NONE) & ~taken & (rd_addr < NIL);
   end

   // link write port: clearing pass first, then the program
   always_comb begin
      if (init_ff) begin
         lk_addr  = init_cnt_ff;
         lk_wdata = LW'(init_cnt_ff + 1'b1);
         lk_we    = 1'b1;
      end else begin
         case (ctl.wa)
            alle_pkg::WA_NODE: lk_addr = node_ff;
            alle_pkg::WA_CUR:  lk_addr = cur_ff;
            alle_pkg::WA_PRV:  lk_addr = prv_ff;
            default:           lk_addr = NIL;
         endcase
         case (ctl.wv)
            alle_pkg::WV_HEAD:  lk_wdata = head_ff;
            alle_pkg::WV_PRV:   lk_wdata = prv_ff;
            alle_pkg::WV_NODE:  lk_wdata = node_ff;
            alle_pkg::WV_FREE:  lk_wdata = free_ff;
            alle_pkg::WV_RLINK: lk_wdata = rlink;
            default:            lk_wdata = NIL;
         endcase
         lk_we = go & (ctl.wa != alle_pkg::WA_NONE) & (lk_addr < NIL);
      end
   end

   assign dt_we = go & ctl.wd & (free_ff < NIL);

   always_comb begin
      init_in        = init_ff;
      init_cnt_in    = init_cnt_ff;
      busy_in        = busy_ff;
      upc_in         = upc_ff;
      pre_status_in  = pre_status_ff;
      head_in        = head_ff;
      free_in        = free_ff;
      cur_in         = cur_ff;
      prv_in         = prv_ff;
      node_in        = node_ff;
      item_in        = item_ff;
      key_in         = key_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;

      // chain node i to i+1; the last one lands on null
      if (init_ff) begin
         init_cnt_in = LW'(init_cnt_ff + 1'b1);
         if (init_cnt_ff == LW'(NODE_COUNT - 1)) begin
            init_in = 1'b0;
         end
      end

      // drop the response beat once taken
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // dispatch: latch the request and pick the program
      if (req_take) begin
         busy_in       = 1'b1;
         item_in       = item_wide[DATA_WIDTH-1:0];
         key_in        = key_wide[DATA_WIDTH-1:0];
         removed_in    = '0;
         pre_status_in = alle_pkg::ST_OK;
         upc_in        = alle_pkg::S_ERR;
         if ((req_func inside {[alle_pkg::FUNC_INS_FRONT:alle_pkg::FUNC_INS_AFTER]})
             && (free_ff >= NIL)) begin
            pre_status_in = alle_pkg::ST_FULL;
         end else if ((req_func inside
                       {[alle_pkg::FUNC_DEL_FRONT:alle_pkg::FUNC_DEL_AFTER]})
                      && (head_ff >= NIL)) begin
            pre_status_in = alle_pkg::ST_EMPTY;
         end else begin
            case (req_func)
               alle_pkg::FUNC_INS_FRONT: upc_in = alle_pkg::S_I0A;
               alle_pkg::FUNC_INS_END:   upc_in = alle_pkg::S_I1A;
               alle_pkg::FUNC_INS_AFTER: upc_in = alle_pkg::S_K2A;
               alle_pkg::FUNC_DEL_FRONT: upc_in = alle_pkg::S_D3A;
               alle_pkg::FUNC_DEL_END:   upc_in = alle_pkg::S_D4A;
               alle_pkg::FUNC_DEL_AFTER: upc_in = alle_pkg::S_K5A;
               default:                  upc_in = alle_pkg::S_ERR;
            endcase
         end
      end

      // execute one control word
      if (go) begin
         upc_in = taken ? ctl.jmp : ctl.nxt;

         if (rd_en) begin
            case (ctl.rd)
               alle_pkg::RD_HEAD: cur_in = head_ff;
               alle_pkg::RD_FREE: node_in = free_ff;
               alle_pkg::RD_NEXT: begin
                  prv_in = cur_ff;
                  cur_in = rlink;
               end
               default: begin
               end
            endcase
         end
         if (ctl.sv) begin
            prv_in = rlink;
         end

         case (ctl.hd)
            alle_pkg::HD_NODE:  head_in = node_ff;
            alle_pkg::HD_RLINK: head_in = rlink;
            alle_pkg::HD_NULL:  head_in = NIL;
            default:            head_in = head_ff;
         endcase
         case (ctl.fr)
            alle_pkg::FR_RLINK: free_in = rlink;
            alle_pkg::FR_CUR:   free_in = cur_ff;
            default:            free_in = free_ff;
         endcase

         if (ctl.rm) begin
            removed_in = rdata;
         end

         // final step: load the response register and go idle
         if (ctl.fin != alle_pkg::FIN_NONE) begin
            busy_in        = 1'b0;
            rsp_valid_in   = 1'b1;
            rsp_removed_in = removed_wide[31:0];
            case (ctl.fin)
               alle_pkg::FIN_OK:     rsp_status_in = alle_pkg::ST_OK;
               alle_pkg::FIN_NOKEY:  rsp_status_in = alle_pkg::ST_NOKEY;
               alle_pkg::FIN_NOSUCC: rsp_status_in = alle_pkg::ST_NOSUCC;
               default:              rsp_status_in = pre_status_ff;
            endcase
            // a step that captures and finishes passes rdata on directly
            if (ctl.rm) begin
               rsp_removed_in = 32'(64'(signed'(rdata)));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= 1'b1;
         init_cnt_ff  <= '0;
         busy_ff      <= 1'b0;
         upc_ff       <= alle_pkg::S_ERR;
         head_ff      <= NIL;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         init_cnt_ff  <= init_cnt_in;
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pre_status_ff  <= pre_status_in;
      cur_ff         <= cur_in;
      prv_ff         <= prv_in;
      node_ff        <= node_in;
      item_ff        <= item_in;
      key_ff         <= key_in;
      removed_ff     <= removed_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   alle_node_store #(
      .NODE_COUNT (NODE_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr[IW-1:0]),
      .lk_we    (lk_we),
      .lk_addr  (lk_addr[IW-1:0]),
      .lk_wdata (lk_wdata),
      .dt_we    (dt_we),
      .dt_addr  (free_ff[IW-1:0]),
      .dt_wdata (item_ff),
      .rd_link  (rlink),
      .rd_data  (rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;

endmodule
